>>> design/ppgafp_pkg.sv
// Package for the optical frame packer: widths, frame constants, the job
// record passed from front to back, and the back-end state type.
// No dependencies.
package ppgafp_pkg;

	localparam int SUM_W     = 24;
	localparam int SAMPLE_W  = 18;
	localparam int TALLY_W   = 5;
	localparam int AVG_W     = 16;
	localparam int AVG_SHIFT = 2;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 16;
	localparam int MAX_BATCH = 31;
	localparam int FRAME_LEN = 21;
	localparam int IDX_W     = 5;
	localparam int DIV_CNT_W = 5;

	localparam logic [TALLY_W-1:0]   MAX_TALLY = TALLY_W'(MAX_BATCH);
	localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(FRAME_LEN - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(SUM_W - 1);

	localparam logic [BYTE_W-1:0] SYNC_A     = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_B     = 8'hBB;
	localparam logic [BYTE_W-1:0] TRAILER    = 8'hCC;
	localparam logic [BYTE_W-1:0] HR_TEMP_HI = 8'h00;
	localparam logic [BYTE_W-1:0] HR_TEMP_LO = 8'hFF;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_FRAME  = 1'b1;

	typedef struct packed {
		logic                spo2;
		logic [TALLY_W-1:0]  tally;
		logic [SUM_W-1:0]    red_sum;
		logic [SUM_W-1:0]    ir_sum;
		logic [WORD_W-1:0]   adc_a;
		logic [WORD_W-1:0]   adc_b;
		logic [WORD_W-1:0]   adc_c;
		logic [WORD_W-1:0]   adc_d;
		logic [BYTE_W-1:0]   acc_x;
		logic [BYTE_W-1:0]   acc_y;
		logic [BYTE_W-1:0]   acc_z;
		logic [BYTE_W-1:0]   temp_int;
		logic [BYTE_W-1:0]   temp_frac;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

endpackage

>>> design/ppg_average_frame_packer_core.sv
// Optical frame packer, top level. A sample request gives no result; a frame request
// becomes a job in the job queue. In SpO2 mode with samples its sums first go through
// a bit-serial divide; the frame bytes then leave through the result buffer, one byte
// a cycle while pop keeps up. Samples are taken one a cycle while the job queue has
// room; the back end starts a frame only after the last one ends. Reset (arst_n low)
// clears the sums, count, held averages, mode and both queues at once; no clearing pass.
module ppg_average_frame_packer_core import ppgafp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              push,
	output logic              full,
	input  logic              req_type,
	input  logic [23:0]       red_sample,
	input  logic [23:0]       ir_sample,
	input  logic [WORD_W-1:0] adc_word_a,
	input  logic [WORD_W-1:0] adc_word_b,
	input  logic [WORD_W-1:0] adc_word_c,
	input  logic [WORD_W-1:0] adc_word_d,
	input  logic [BYTE_W-1:0] acc_x_high,
	input  logic [BYTE_W-1:0] acc_y_high,
	input  logic [BYTE_W-1:0] acc_z_high,
	input  logic [BYTE_W-1:0] temp_int,
	input  logic [BYTE_W-1:0] temp_frac,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] frame_byte,
	output logic              frame_last,
	// mode register
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data
);

	// Front to queue: a frame request becomes one job holding a snapshot of
	// the sums, the count, the mode and the frame fields.
	logic job_push;
	job_t job_in;
	// Queue to back end.
	logic q_full;
	logic q_valid;
	logic q_pop;
	job_t q_job;

	// Hold requests only when the job queue has no room; samples and frame
	// requests share the one full flag so it never depends on the payload.
	assign full = q_full;

	ppgafp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (q_full),
		.req_type    (req_type),
		.red_sample  (red_sample),
		.ir_sample   (ir_sample),
		.adc_word_a  (adc_word_a),
		.adc_word_b  (adc_word_b),
		.adc_word_c  (adc_word_c),
		.adc_word_d  (adc_word_d),
		.acc_x_high  (acc_x_high),
		.acc_y_high  (acc_y_high),
		.acc_z_high  (acc_z_high),
		.temp_int    (temp_int),
		.temp_frac   (temp_frac),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.job_push    (job_push),
		.job         (job_in)
	);

	// Two jobs of slack let the front keep accumulating the next batch while
	// the back end is still sending a frame.
	ppgafp_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wr_job (job_in),
		.full   (q_full),
		.valid  (q_valid),
		.rd_job (q_job),
		.rd     (q_pop)
	);

	// Back end: divide if needed, update the held averages, then stream the
	// frame with its running checksum into the result buffer.
	ppgafp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_valid),
		.job        (q_job),
		.job_pop    (q_pop),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule

>>> design/ppgafp_front.sv
// Front end: takes requests, accumulates optical samples and snapshots a
// frame job on each frame request. Depends on ppgafp_pkg.
module ppgafp_front import ppgafp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic                req_type,
	input  logic [23:0]         red_sample,
	input  logic [23:0]         ir_sample,
	input  logic [WORD_W-1:0]   adc_word_a,
	input  logic [WORD_W-1:0]   adc_word_b,
	input  logic [WORD_W-1:0]   adc_word_c,
	input  logic [WORD_W-1:0]   adc_word_d,
	input  logic [BYTE_W-1:0]   acc_x_high,
	input  logic [BYTE_W-1:0]   acc_y_high,
	input  logic [BYTE_W-1:0]   acc_z_high,
	input  logic [BYTE_W-1:0]   temp_int,
	input  logic [BYTE_W-1:0]   temp_frac,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	output logic                job_push,
	output job_t                job
);

	logic               spo2_q;
	logic [SUM_W-1:0]   red_sum_q;
	logic [SUM_W-1:0]   ir_sum_q;
	logic [TALLY_W-1:0] tally_q;
	logic               accept;
	logic               take_sample;

	assign accept      = push && !q_full;
	assign take_sample = accept && (req_type == REQ_SAMPLE) && (tally_q < MAX_TALLY);
	assign job_push    = accept && (req_type == REQ_FRAME);

	always_comb begin
		job.spo2      = spo2_q;
		job.tally     = tally_q;
		job.red_sum   = red_sum_q;
		job.ir_sum    = ir_sum_q;
		job.adc_a     = adc_word_a;
		job.adc_b     = adc_word_b;
		job.adc_c     = adc_word_c;
		job.adc_d     = adc_word_d;
		job.acc_x     = acc_x_high;
		job.acc_y     = acc_y_high;
		job.acc_z     = acc_z_high;
		job.temp_int  = temp_int;
		job.temp_frac = temp_frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spo2_q    <= 1'b0;
			red_sum_q <= '0;
			ir_sum_q  <= '0;
			tally_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				spo2_q <= cfg_wr_data;
			end
			if (job_push) begin
				red_sum_q <= '0;
				ir_sum_q  <= '0;
				tally_q   <= '0;
			end else if (take_sample) begin
				red_sum_q <= red_sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, red_sample[SAMPLE_W-1:0]};
				ir_sum_q  <= ir_sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, ir_sample[SAMPLE_W-1:0]};
				tally_q   <= tally_q + TALLY_W'(1);
			end
		end
	end

endmodule

>>> design/ppgafp_jobq.sv
// Two-entry queue of frame jobs between the front and back ends.
// Depends on ppgafp_pkg.
module ppgafp_jobq import ppgafp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	output logic full,
	output logic valid,
	output job_t rd_job,
	input  logic rd
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign valid  = (cnt_q != 2'd0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd && valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, (wr && !full)} - {1'b0, (rd && valid)};
		end
	end

endmodule

>>> design/ppgafp_div.sv
// Restoring divider, one quotient bit per cycle: 24-bit sum by 5-bit count.
// Depends on ppgafp_pkg.
module ppgafp_div import ppgafp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [TALLY_W-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [SUM_W-1:0]   quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [TALLY_W-1:0]   rem_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [TALLY_W-1:0]   dsr_q;
	logic [TALLY_W:0]     trial;
	logic [TALLY_W:0]     diff;
	logic                 fits;

	assign trial    = {rem_q, dvd_q[SUM_W-1]};
	assign fits     = (trial >= {1'b0, dsr_q});
	assign diff     = trial - {1'b0, dsr_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TALLY_W-1:0] : trial[TALLY_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_CNT_W'(1);
				if (step_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> design/ppgafp_back.sv
// Back end: takes a frame job, runs the SpO2 averaging divides if it has samples and sends the
// 21 frame bytes through a two-entry result buffer. Depends on ppgafp_pkg, ppgafp_div.
module ppgafp_back import ppgafp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              job_pop,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] frame_byte,
	output logic              frame_last
);

	back_state_t       state_q, state_d;
	job_t              job_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] xor_q;
	logic [AVG_W-1:0]  held_red_q;
	logic [AVG_W-1:0]  held_ir_q;
	logic              div_start;
	logic              red_busy, ir_busy, red_done, ir_done;
	logic [SUM_W-1:0]  red_quot, ir_quot;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;

	logic [BYTE_W-1:0] ob_byte_q [2];
	logic              ob_last_q [2];
	logic              ob_wr_q, ob_rd_q;
	logic [1:0]        ob_cnt_q;
	logic              ob_full, ob_push, ob_pop;

	ppgafp_div u_div_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (job.red_sum),
		.divisor  (job.tally),
		.busy     (red_busy),
		.done     (red_done),
		.quotient (red_quot)
	);

	ppgafp_div u_div_ir (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (job.ir_sum),
		.divisor  (job.tally),
		.busy     (ir_busy),
		.done     (ir_done),
		.quotient (ir_quot)
	);

	// frame byte for the current position
	always_comb begin
		emit_last = (idx_q == LAST_IDX);
		unique case (idx_q)
			5'd0:  emit_byte = SYNC_A;
			5'd1:  emit_byte = SYNC_B;
			5'd2:  emit_byte = job_q.adc_a[15:8];
			5'd3:  emit_byte = job_q.adc_a[7:0];
			5'd4:  emit_byte = job_q.adc_b[15:8];
			5'd5:  emit_byte = job_q.adc_b[7:0];
			5'd6:  emit_byte = job_q.adc_c[15:8];
			5'd7:  emit_byte = job_q.adc_c[7:0];
			5'd8:  emit_byte = job_q.adc_d[15:8];
			5'd9:  emit_byte = job_q.adc_d[7:0];
			5'd10: emit_byte = job_q.acc_x;
			5'd11: emit_byte = job_q.acc_y;
			5'd12: emit_byte = job_q.acc_z;
			5'd13: emit_byte = job_q.spo2 ? held_red_q[15:8] : job_q.red_sum[23:16];
			5'd14: emit_byte = job_q.spo2 ? held_red_q[7:0]  : job_q.red_sum[15:8];
			5'd15: emit_byte = job_q.spo2 ? held_ir_q[15:8]  : job_q.red_sum[7:0];
			5'd16: emit_byte = job_q.spo2 ? held_ir_q[7:0]
						: {{(BYTE_W-TALLY_W){1'b0}}, job_q.tally};
			5'd17: emit_byte = job_q.spo2 ? job_q.temp_int  : HR_TEMP_HI;
			5'd18: emit_byte = job_q.spo2 ? job_q.temp_frac : HR_TEMP_LO;
			5'd19: emit_byte = xor_q;
			5'd20: emit_byte = TRAILER;
			default: emit_byte = '0;
		endcase
	end

	assign ob_full    = (ob_cnt_q == 2'd2);
	assign empty      = (ob_cnt_q == 2'd0);
	assign ob_push    = (state_q == BK_EMIT) && !ob_full;
	assign ob_pop     = pop && !empty;
	assign frame_byte = ob_byte_q[ob_rd_q];
	assign frame_last = ob_last_q[ob_rd_q];

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					if (job.spo2 && (job.tally != '0)) begin
						div_start = 1'b1;
						state_d   = BK_DIV;
					end else begin
						state_d = BK_EMIT;
					end
				end
			end
			BK_DIV: begin
				if (red_done) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (ob_push && emit_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_valid) begin
			job_q <= job;
		end
		if (ob_push) begin
			ob_byte_q[ob_wr_q] <= emit_byte;
			ob_last_q[ob_wr_q] <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			idx_q      <= '0;
			xor_q      <= '0;
			held_red_q <= '0;
			held_ir_q  <= '0;
			ob_wr_q    <= 1'b0;
			ob_rd_q    <= 1'b0;
			ob_cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE) begin
				idx_q <= '0;
				xor_q <= '0;
			end else if (ob_push) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q >= 5'd2 && idx_q <= 5'd18) begin
					xor_q <= xor_q ^ emit_byte;
				end
			end
			if (red_done) begin
				held_red_q <= red_quot[AVG_SHIFT +: AVG_W];
				held_ir_q  <= ir_quot[AVG_SHIFT +: AVG_W];
			end
			if (ob_push) begin
				ob_wr_q <= ~ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= ~ob_rd_q;
			end
			ob_cnt_q <= ob_cnt_q + {1'b0, ob_push} - {1'b0, ob_pop};
		end
	end

	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(red_busy == ir_busy) && (red_done == ir_done))
		else $error("divider lanes out of step");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (red_busy || red_done))
		else $error("waiting on divider that is not running");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ob_push && emit_last) |=> (state_q == BK_IDLE))
		else $error("closing byte sent without ending the frame");

endmodule
